### rtl/core/egs_pkg.sv
// Shared types, widths and constants of the endpoint Gaussian similarity unit.
package egs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PT_W           = 48;
    localparam int SIGMA_W        = 16;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd1024;
    localparam int DEN_W          = 33;
    localparam logic [DEN_W-1:0] DEN_RESET = 33'd2097152;
    localparam int Q_W            = 20;
    localparam int FRAC_W         = 16;
    localparam int X_W            = Q_W + FRAC_W;
    localparam int N_W            = 5;
    localparam int R_W            = 32;
    localparam logic [X_W-1:0] LN2_Q32 = 36'd2977044472;
    localparam int SUM_W          = 34;
    localparam logic [SUM_W-1:0] ONE_Q32 = 34'h1_0000_0000;
    localparam int TERMS          = 13;
    localparam int RECIP_W        = 36;
    localparam int RECIP_SHIFT    = 36;
    localparam int KERN_W         = 17;
    localparam int SIM_W          = 18;
    localparam logic [SIM_W-1:0] SIM_MAX = 18'd131072;
    localparam int PIPE_DEPTH     = 65;

    typedef struct packed {
        logic valid;
        logic kill;
    } egs_ctl_t;

    // ceil(2^36 / k): exact floor division of a 32-bit value by k
    function automatic logic [RECIP_W-1:0] recip_of(input int k);
        logic [RECIP_W-1:0] m;
        case (k)
            3:       m = 36'd22906492246;
            5:       m = 36'd13743895348;
            6:       m = 36'd11453246123;
            7:       m = 36'd9817068106;
            9:       m = 36'd7635497416;
            10:      m = 36'd6871947674;
            11:      m = 36'd6247225158;
            12:      m = 36'd5726623062;
            13:      m = 36'd5286113596;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/egs_dist.sv
// Front end: coordinate differences, squares and squared distances of both pairings.
module egs_dist
    import egs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = 2 * COORD_BITS + 3
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  egs_ctl_t        ctl_in,
    input  logic [PT_W-1:0] first_start,
    input  logic [PT_W-1:0] first_end,
    input  logic [PT_W-1:0] second_start,
    input  logic [PT_W-1:0] second_end,
    output egs_ctl_t        ctl_out,
    output logic [DW-1:0]   d_straight,
    output logic [DW-1:0]   d_flipped
);

    localparam int CB  = COORD_BITS;
    localparam int WW  = (3 * CB > PT_W) ? 3 * CB : PT_W;
    localparam int SQW = 2 * CB + 1;
    localparam int PA [0:3] = '{0, 1, 0, 1};
    localparam int PB [0:3] = '{2, 3, 3, 2};

    logic [WW-1:0]        pt [0:3];
    logic signed [CB:0]   diff_reg [0:3][0:2];
    logic [SQW-1:0]       sq_reg [0:3][0:2];
    logic [DW-1:0]        d_s_reg;
    logic [DW-1:0]        d_f_reg;
    egs_ctl_t             ctl1_reg;
    egs_ctl_t             ctl2_reg;
    egs_ctl_t             ctl3_reg;

    assign pt[0] = WW'(first_start);
    assign pt[1] = WW'(first_end);
    assign pt[2] = WW'(second_start);
    assign pt[3] = WW'(second_end);

    for (genvar p = 0; p < 4; p++)
    begin : g_pair
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            logic signed [CB:0]     ca;
            logic signed [CB:0]     cb;
            logic signed [2*CB+1:0] prod;

            assign ca   = $signed({pt[PA[p]][a*CB+CB-1], pt[PA[p]][a*CB +: CB]});
            assign cb   = $signed({pt[PB[p]][a*CB+CB-1], pt[PB[p]][a*CB +: CB]});
            assign prod = diff_reg[p][a] * diff_reg[p][a];

            always_ff @(posedge clk)
            begin
                diff_reg[p][a] <= ca - cb;
                sq_reg[p][a]   <= prod[SQW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_s_reg <= DW'(sq_reg[0][0]) + DW'(sq_reg[0][1]) + DW'(sq_reg[0][2])
                 + DW'(sq_reg[1][0]) + DW'(sq_reg[1][1]) + DW'(sq_reg[1][2]);
        d_f_reg <= DW'(sq_reg[2][0]) + DW'(sq_reg[2][1]) + DW'(sq_reg[2][2])
                 + DW'(sq_reg[3][0]) + DW'(sq_reg[3][1]) + DW'(sq_reg[3][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    assign ctl_out    = ctl3_reg;
    assign d_straight = d_s_reg;
    assign d_flipped  = d_f_reg;

endmodule

### rtl/core/egs_div.sv
// Scaling lane: D*2^16/den one quotient bit per stage, then split by ln2 into n and r.
module egs_div
    import egs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = 2 * COORD_BITS + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  egs_ctl_t         ctl_in,
    input  logic [DW-1:0]    d_in,
    input  logic [DEN_W-1:0] den,
    output egs_ctl_t         ctl_out,
    output logic [N_W-1:0]   n_out,
    output logic [R_W-1:0]   r_out
);

    localparam int XW = (DW > DEN_W + 4) ? DW : DEN_W + 4;

    logic [XW-1:0]    d_wide;
    logic [XW-1:0]    d_limit;
    logic             under;

    egs_ctl_t         ctl_reg  [0:Q_W];
    logic [DEN_W-1:0] rem_reg  [0:Q_W-1];
    logic [Q_W-1:0]   feed_reg [0:Q_W-1];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];

    egs_ctl_t         ctl_l_reg [1:N_W];
    logic [X_W-1:0]   xr_reg    [1:N_W];
    logic [N_W-1:0]   nq_reg    [1:N_W];
    logic [X_W-1:0]   x0;

    assign d_wide  = XW'(d_in);
    assign d_limit = XW'({den, 4'b0000});
    assign under   = d_wide >= d_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else
        begin
            ctl_reg[0].valid <= ctl_in.valid;
            ctl_reg[0].kill  <= ctl_in.kill | under;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= d_wide[DEN_W+3:4];
        feed_reg[0] <= {d_wide[3:0], {(Q_W-4){1'b0}}};
        quo_reg[0]  <= '0;
    end

    for (genvar i = 1; i <= Q_W; i++)
    begin : g_div
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[i-1], feed_reg[i-1][Q_W-1]};
        assign ge    = trial >= {1'b0, den};
        assign diff  = trial - {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else
                ctl_reg[i] <= ctl_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            quo_reg[i] <= {quo_reg[i-1][Q_W-2:0], ge};
        end

        if (i < Q_W)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                feed_reg[i] <= {feed_reg[i-1][Q_W-2:0], 1'b0};
            end
        end
    end

    assign x0 = {quo_reg[Q_W], {FRAC_W{1'b0}}};

    for (genvar j = 1; j <= N_W; j++)
    begin : g_ln2
        localparam int B = N_W - j;
        localparam logic [X_W-1:0] CMP = LN2_Q32 << B;

        logic [X_W-1:0] xin;
        logic [N_W-1:0] nin;
        egs_ctl_t       cin;
        logic           ge;

        if (j == 1)
        begin : g_first
            assign xin = x0;
            assign nin = '0;
            assign cin = ctl_reg[Q_W];
        end
        else
        begin : g_next
            assign xin = xr_reg[j-1];
            assign nin = nq_reg[j-1];
            assign cin = ctl_l_reg[j-1];
        end

        assign ge = xin >= CMP;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_l_reg[j] <= '0;
            else
                ctl_l_reg[j] <= cin;
        end

        always_ff @(posedge clk)
        begin
            xr_reg[j] <= ge ? xin - CMP : xin;
            nq_reg[j] <= nin | (N_W'(ge) << B);
        end
    end

    assign ctl_out = ctl_l_reg[N_W];
    assign n_out   = nq_reg[N_W];
    assign r_out   = xr_reg[N_W][R_W-1:0];

endmodule

### rtl/core/egs_exp.sv
// Kernel lane: exp(-r) series one term per stage group, then scale by 2^-n with rounding.
module egs_exp
    import egs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  egs_ctl_t          ctl_in,
    input  logic [N_W-1:0]    n_in,
    input  logic [R_W-1:0]    r_in,
    output egs_ctl_t          ctl_out,
    output logic [KERN_W-1:0] kernel
);

    egs_ctl_t          ctl_reg  [1:TERMS];
    logic [SUM_W-1:0]  sum_reg  [1:TERMS];
    logic [N_W-1:0]    n_reg    [1:TERMS];
    logic [R_W-1:0]    term_reg [1:TERMS-1];
    logic [R_W-1:0]    r_reg    [1:TERMS-1];

    egs_ctl_t          ctl_o_reg;
    logic [KERN_W-1:0] kernel_reg;
    logic [5:0]        sh;
    logic [39:0]       rounded;

    // first term of the series is r itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[1] <= '0;
        else
            ctl_reg[1] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        term_reg[1] <= r_in;
        r_reg[1]    <= r_in;
        sum_reg[1]  <= ONE_Q32 - SUM_W'(r_in);
        n_reg[1]    <= n_in;
    end

    for (genvar k = 2; k <= TERMS; k++)
    begin : g_term
        localparam bit POW2 = (k & (k - 1)) == 0;
        localparam bit ODD  = (k % 2) == 1;

        logic [2*R_W-1:0] prod_reg;
        egs_ctl_t         ctl_a_reg;
        logic [SUM_W-1:0] sum_a_reg;
        logic [N_W-1:0]   n_a_reg;
        logic [R_W-1:0]   v;
        logic [R_W-1:0]   t;
        egs_ctl_t         ctl_p;
        logic [SUM_W-1:0] sum_p;
        logic [N_W-1:0]   n_p;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_a_reg <= '0;
            else
                ctl_a_reg <= ctl_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            prod_reg  <= (2*R_W)'(term_reg[k-1]) * (2*R_W)'(r_reg[k-1]);
            sum_a_reg <= sum_reg[k-1];
            n_a_reg   <= n_reg[k-1];
        end

        assign v = prod_reg[2*R_W-1:R_W];

        if (POW2)
        begin : g_shift
            assign t     = v >> $clog2(k);
            assign ctl_p = ctl_a_reg;
            assign sum_p = sum_a_reg;
            assign n_p   = n_a_reg;
        end
        else
        begin : g_recip
            logic [R_W+RECIP_W-1:0] scaled_reg;
            egs_ctl_t               ctl_b_reg;
            logic [SUM_W-1:0]       sum_b_reg;
            logic [N_W-1:0]         n_b_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_b_reg <= '0;
                else
                    ctl_b_reg <= ctl_a_reg;
            end

            always_ff @(posedge clk)
            begin
                scaled_reg <= (R_W+RECIP_W)'(v) * (R_W+RECIP_W)'(recip_of(k));
                sum_b_reg  <= sum_a_reg;
                n_b_reg    <= n_a_reg;
            end

            assign t     = scaled_reg[RECIP_SHIFT+R_W-1:RECIP_SHIFT];
            assign ctl_p = ctl_b_reg;
            assign sum_p = sum_b_reg;
            assign n_p   = n_b_reg;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else
                ctl_reg[k] <= ctl_p;
        end

        always_ff @(posedge clk)
        begin
            sum_reg[k] <= ODD ? sum_p - SUM_W'(t) : sum_p + SUM_W'(t);
            n_reg[k]   <= n_p;
        end

        if (k < TERMS)
        begin : g_carry
            logic [R_W-1:0] r_a_reg;
            logic [R_W-1:0] r_p;

            always_ff @(posedge clk)
            begin
                r_a_reg <= r_reg[k-1];
            end

            if (POW2)
            begin : g_r_short
                assign r_p = r_a_reg;
            end
            else
            begin : g_r_long
                logic [R_W-1:0] r_b_reg;

                always_ff @(posedge clk)
                begin
                    r_b_reg <= r_a_reg;
                end

                assign r_p = r_b_reg;
            end

            always_ff @(posedge clk)
            begin
                term_reg[k] <= t;
                r_reg[k]    <= r_p;
            end
        end
    end

    // round to nearest at 16 fraction bits after dividing by 2^n
    assign sh      = 6'(n_reg[TERMS]) + 6'd16;
    assign rounded = 40'(sum_reg[TERMS]) + (40'd1 << (sh - 6'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_o_reg <= '0;
        else
            ctl_o_reg <= ctl_reg[TERMS];
    end

    always_ff @(posedge clk)
    begin
        kernel_reg <= KERN_W'(rounded >> sh);
    end

    assign ctl_out = ctl_o_reg;
    assign kernel  = kernel_reg;

endmodule

### rtl/core/endpoint_gaussian_similarity_unit.sv
// Top level of the endpoint Gaussian similarity unit: sigma register, two kernel lanes, sum.
// The path from an accepted item to done runs through 65 register stages.
// Throughput: one item per cycle, set by the fully pipelined divider and series lanes.
// busy is high only while reset is applied and for the first cycle after; results are
// never stalled. Reset clears all valid bits and sets sigma to 64.0.
module endpoint_gaussian_similarity_unit
    import egs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PT_W-1:0]    first_start,
    input  logic [PT_W-1:0]    first_end,
    input  logic [PT_W-1:0]    second_start,
    input  logic [PT_W-1:0]    second_end,
    input  logic               same_tract,
    output logic               done,
    output logic [SIM_W-1:0]   similarity,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SIGMA_W-1:0] cfg_data
);

    localparam int DW = 2 * COORD_BITS + 3;

    logic [SIGMA_W-1:0]   sigma_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [SIGMA_W-1:0]   sigma_eff;
    logic [2*SIGMA_W-1:0] sigma_sq;
    logic [DEN_W-1:0]     den_next;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SIM_W-1:0]     similarity_reg;
    logic                 accept;

    egs_ctl_t             ctl_in;
    egs_ctl_t             ctl_d;
    egs_ctl_t             ctl_s_div;
    egs_ctl_t             ctl_f_div;
    egs_ctl_t             ctl_s_exp;
    egs_ctl_t             ctl_f_exp;
    logic [DW-1:0]        d_straight;
    logic [DW-1:0]        d_flipped;
    logic [N_W-1:0]       n_s;
    logic [N_W-1:0]       n_f;
    logic [R_W-1:0]       r_s;
    logic [R_W-1:0]       r_f;
    logic [KERN_W-1:0]    kern_s;
    logic [KERN_W-1:0]    kern_f;
    logic [KERN_W-1:0]    kern_s_m;
    logic [KERN_W-1:0]    kern_f_m;

    assign accept     = start & ~busy_reg;
    assign cfg_ready  = 1'b1;
    assign ctl_in     = '{valid: accept, kill: same_tract};

    // sigma of zero acts as one
    assign sigma_eff  = (sigma_reg == '0) ? SIGMA_W'(1) : sigma_reg;
    assign sigma_sq   = (2*SIGMA_W)'(sigma_eff) * (2*SIGMA_W)'(sigma_eff);
    assign den_next   = {sigma_sq, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RESET;
            den_reg   <= DEN_RESET;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sigma_reg <= cfg_data;
            den_reg  <= den_next;
            busy_reg <= 1'b0;
            done_reg <= ctl_s_exp.valid & ctl_f_exp.valid;
        end
    end

    egs_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (ctl_in),
        .first_start  (first_start),
        .first_end    (first_end),
        .second_start (second_start),
        .second_end   (second_end),
        .ctl_out      (ctl_d),
        .d_straight   (d_straight),
        .d_flipped    (d_flipped)
    );

    egs_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div_straight (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_d),
        .d_in    (d_straight),
        .den     (den_reg),
        .ctl_out (ctl_s_div),
        .n_out   (n_s),
        .r_out   (r_s)
    );

    egs_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div_flipped (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_d),
        .d_in    (d_flipped),
        .den     (den_reg),
        .ctl_out (ctl_f_div),
        .n_out   (n_f),
        .r_out   (r_f)
    );

    egs_exp u_exp_straight (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_s_div),
        .n_in    (n_s),
        .r_in    (r_s),
        .ctl_out (ctl_s_exp),
        .kernel  (kern_s)
    );

    egs_exp u_exp_flipped (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_f_div),
        .n_in    (n_f),
        .r_in    (r_f),
        .ctl_out (ctl_f_exp),
        .kernel  (kern_f)
    );

    assign kern_s_m = ctl_s_exp.kill ? '0 : kern_s;
    assign kern_f_m = ctl_f_exp.kill ? '0 : kern_f;

    always_ff @(posedge clk)
    begin
        similarity_reg <= SIM_W'(kern_s_m) + SIM_W'(kern_f_m);
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign similarity = similarity_reg;

endmodule

### rtl/core/egs_checker.sv
// Port-level checks of the similarity unit, bound to its top level.
module egs_port_props
    import egs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             same_tract,
    input logic             done,
    input logic [SIM_W-1:0] similarity
);

    logic accepted;

    assign accepted = start && !busy;

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accepted, PIPE_DEPTH))
        else $error("result without an item accepted at the pipeline depth");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> similarity <= SIM_MAX)
        else $error("similarity above 2.0");

    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accepted && same_tract, PIPE_DEPTH) |-> similarity == '0)
        else $error("same polyline item gave a nonzero similarity");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose outside reset");

endmodule

bind endpoint_gaussian_similarity_unit egs_port_props u_egs_port_props (.*);

### tb/egs_checker.sv
// Checker for the endpoint Gaussian similarity unit: watches the ports, predicts and compares.
module egs_checker
    import egs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [PT_W-1:0]    first_start,
    input  logic [PT_W-1:0]    first_end,
    input  logic [PT_W-1:0]    second_start,
    input  logic [PT_W-1:0]    second_end,
    input  logic               same_tract,
    input  logic               done,
    input  logic [SIM_W-1:0]   similarity,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [SIGMA_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CW        = COORD_BITS_DEF;
    localparam longint unsigned LN2_FIX   = 64'd2977044472;
    localparam longint unsigned UNIT_FIX  = 64'd1 << 32;
    localparam int              EXP_TERMS = 13;

    logic [SIGMA_W-1:0] sigma_q;
    logic [SIM_W-1:0]   sim_expect_q[$];
    int                 result_idx;

    function automatic longint signed coord_at(input logic [PT_W-1:0] w, input int axis);
        logic [CW-1:0] v;
        longint signed c;
        v = w[axis*CW +: CW];
        c = $signed(v);
        return c;
    endfunction

    function automatic longint unsigned point_dist2(input logic [PT_W-1:0] a,
                                                    input logic [PT_W-1:0] b);
        longint unsigned acc;
        longint signed   d;
        acc = 0;
        for (int ax = 0; ax < 3; ax++) begin
            d   = coord_at(a, ax) - coord_at(b, ax);
            acc = acc + longint'(d * d);
        end
        return acc;
    endfunction

    // exp(-D/den) at 16 fraction bits, zero once D/den reaches 16
    function automatic longint unsigned gauss_kernel(input longint unsigned dsq,
                                                     input longint unsigned den);
        longint unsigned q, x, n, r, acc, term, sh;
        if (dsq >= 64'd16 * den)
            return 0;
        q    = (dsq << 16) / den;
        x    = q << 16;
        n    = x / LN2_FIX;
        r    = x - n * LN2_FIX;
        acc  = UNIT_FIX;
        term = UNIT_FIX;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * r) >> 32) / longint'(k);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        sh = 16 + n;
        return (acc + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [SIM_W-1:0] predict_similarity(
        input logic [PT_W-1:0]    fs,
        input logic [PT_W-1:0]    fe,
        input logic [PT_W-1:0]    ss,
        input logic [PT_W-1:0]    se,
        input logic               same,
        input logic [SIGMA_W-1:0] sig
    );
        longint unsigned s, den, straight, flipped, total;
        if (same)
            return '0;
        s        = (sig == 0) ? 64'd1 : longint'(sig);
        den      = 64'd2 * s * s;
        straight = point_dist2(fs, ss) + point_dist2(fe, se);
        flipped  = point_dist2(fs, se) + point_dist2(fe, ss);
        total    = gauss_kernel(straight, den) + gauss_kernel(flipped, den);
        return total[SIM_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk) begin
        logic [SIM_W-1:0] want;
        if (!rst_n) begin
            sigma_q <= SIGMA_RESET;
            sim_expect_q.delete();
        end
        else begin
            if (done !== 1'b0) begin
                if (sim_expect_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no item pending, similarity=%0d",
                                              result_idx, similarity));
                else begin
                    want = sim_expect_q.pop_front();
                    if (done !== 1'b1 || similarity !== want)
                        report_mismatch($sformatf("result %0d similarity=%0d done=%b want %0d",
                                                  result_idx, similarity, done, want));
                end
                result_idx++;
            end
            if (start && !busy)
                sim_expect_q.push_back(predict_similarity(first_start, first_end, second_start,
                                                          second_end, same_tract, sigma_q));
            if (cfg_valid && cfg_ready)
                sigma_q <= cfg_data;
        end
        pending <= sim_expect_q.size();
    end

endmodule

### tb/tb_top.sv
// Top of the endpoint Gaussian similarity unit testbench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import egs_pkg::*;

    localparam int PHASES     = 7;
    localparam int PHASE_LEN  = 60;
    localparam int CW         = COORD_BITS_DEF;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [PT_W-1:0]    first_start  = '0;
    logic [PT_W-1:0]    first_end    = '0;
    logic [PT_W-1:0]    second_start = '0;
    logic [PT_W-1:0]    second_end   = '0;
    logic               same_tract   = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic [SIGMA_W-1:0] cfg_data     = '0;
    logic               busy;
    logic               done;
    logic [SIM_W-1:0]   similarity;
    logic               cfg_ready;
    int                 fail_count;
    int                 pending;

    logic [SIGMA_W-1:0] phase_sigma[PHASES];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    endpoint_gaussian_similarity_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_start  (first_start),
        .first_end    (first_end),
        .second_start (second_start),
        .second_end   (second_end),
        .same_tract   (same_tract),
        .done         (done),
        .similarity   (similarity),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    egs_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_start  (first_start),
        .first_end    (first_end),
        .second_start (second_start),
        .second_end   (second_end),
        .same_tract   (same_tract),
        .done         (done),
        .similarity   (similarity),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    function automatic logic [PT_W-1:0] pack_point(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [PT_W-1:0] rand_point();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PT_W-1:0];
    endfunction

    function automatic logic [PT_W-1:0] extreme_point();
        logic [PT_W-1:0] p;
        logic [CW-1:0]   c;
        for (int ax = 0; ax < 3; ax++) begin
            case ($urandom_range(0, 3))
                0:       c = 16'h8000;
                1:       c = 16'h7FFF;
                2:       c = 16'h0000;
                default: c = 16'hFFFF;
            endcase
            p[ax*CW +: CW] = c;
        end
        return p;
    endfunction

    function automatic logic [PT_W-1:0] near_point(input logic [PT_W-1:0] p, input int spread);
        logic [PT_W-1:0] q;
        int              off;
        for (int ax = 0; ax < 3; ax++) begin
            off = int'($urandom_range(0, 2 * spread)) - spread;
            q[ax*CW +: CW] = p[ax*CW +: CW] + CW'(off);
        end
        return q;
    endfunction

    task automatic send_item(input logic [PT_W-1:0] a, input logic [PT_W-1:0] b,
                             input logic [PT_W-1:0] c, input logic [PT_W-1:0] d,
                             input logic st);
        start        <= 1'b1;
        first_start  <= a;
        first_end    <= b;
        second_start <= c;
        second_end   <= d;
        same_tract   <= st;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_sigma(input logic [SIGMA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int spread);
        int              sel;
        logic [PT_W-1:0] a, b, c, d;
        logic            st;
        logic            flip;
        sel  = $urandom_range(0, 99);
        a    = rand_point();
        b    = rand_point();
        c    = rand_point();
        d    = rand_point();
        st   = 1'b0;
        flip = $urandom_range(0, 1);
        if (sel < 55) begin
            if ($urandom_range(0, 1))
                b = near_point(a, spread * 2);
            c = flip ? near_point(b, spread) : near_point(a, spread);
            d = flip ? near_point(a, spread) : near_point(b, spread);
        end
        else if (sel < 65) begin
            b = near_point(a, spread);
            c = near_point(a, spread);
            d = near_point(a, spread);
        end
        else if (sel < 78) begin
            st = $urandom_range(0, 1);
        end
        else if (sel < 88) begin
            c  = near_point(a, spread);
            d  = near_point(b, spread);
            st = 1'b1;
        end
        else if (sel < 94) begin
            a  = extreme_point();
            b  = extreme_point();
            c  = extreme_point();
            d  = extreme_point();
            st = ($urandom_range(0, 3) == 0);
        end
        else begin
            c = flip ? b : a;
            d = flip ? a : b;
        end
        send_item(a, b, c, d, st);
    endtask

    task automatic directed_items();
        logic [PT_W-1:0] zero, pmax, pmin, ones;
        zero = '0;
        pmax = pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        pmin = pack_point(16'h8000, 16'h8000, 16'h8000);
        ones = '1;
        send_item(zero, zero, zero, zero, 1'b0);
        send_item(zero, zero, zero, zero, 1'b1);
        send_item(pmax, pmax, pmax, pmax, 1'b0);
        send_item(pmin, pmin, pmin, pmin, 1'b0);
        send_item(pmax, pmax, pmin, pmin, 1'b0);
        send_item(pmin, pmax, pmin, pmax, 1'b0);
        send_item(pmin, pmax, pmax, pmin, 1'b0);
        // underflow edge at sigma 64.0: 5792^2 just below 16*den, 5793^2 above
        send_item(zero, zero, pack_point(16'd5792, 16'd0, 16'd0), zero, 1'b0);
        send_item(zero, zero, pack_point(16'd5793, 16'd0, 16'd0), zero, 1'b0);
        send_item(zero, zero, pack_point(16'd0, 16'd0, -16'sd5792), zero, 1'b0);
        send_item(ones, ones, zero, zero, 1'b0);
        send_item(ones, ones, ones, ones, 1'b1);
        send_item(zero, zero, pack_point(16'd1, 16'd0, 16'd0), zero, 1'b0);
        send_item(zero, pack_point(16'd0, 16'd1000, -16'sd1000),
                  pack_point(16'd0, 16'd1000, -16'sd1000), zero, 1'b0);
        send_item(pack_point(16'd300, -16'sd200, 16'd0), zero,
                  pack_point(16'd320, -16'sd180, 16'd10), pack_point(16'd5, 16'd5, 16'd5), 1'b0);
    endtask

    initial begin
        int sig_eff;
        int cap;
        int idle_pct;
        phase_sigma[0] = 16'd16;
        phase_sigma[1] = 16'd0;
        phase_sigma[2] = 16'd1;
        phase_sigma[3] = 16'hFFFF;
        phase_sigma[4] = SIGMA_W'($urandom_range(2, 4000));
        phase_sigma[5] = 16'd300;
        phase_sigma[6] = 16'd1024;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        directed_items();

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_sigma(phase_sigma[p]);
            sig_eff  = (phase_sigma[p] == 0) ? 1 : int'(phase_sigma[p]);
            cap      = (sig_eff * 3 > 30000) ? 30000 : sig_eff * 3;
            idle_pct = (p == PHASES - 1) ? 0 : (p % 3) * 20 + 10;
            for (int i = 0; i < PHASE_LEN; i++) begin
                random_item($urandom_range(1, cap));
                if (p == 2 && i == PHASE_LEN / 2)
                    wait_drained();
                else if ($urandom_range(0, 99) < idle_pct)
                    hold_off($urandom_range(1, 19));
            end
        end

        wait_drained();
        repeat (PIPE_DEPTH + 16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("endpoint_gaussian_similarity_unit verification clean");
        else
            $display("endpoint_gaussian_similarity_unit verification failed");
        $finish;
    end

    initial begin
        #400000;
        $display("endpoint_gaussian_similarity_unit verification failed");
        $finish;
    end

endmodule
